@@ rtl/core/hpti_pkg.sv @@
// ----------------------------------------------------------------------------
// hpti_pkg: shared types and constants for the Hilbert point-to-index block
// Register indexes, error codes, and the per-item bundle passed between cells.
// ----------------------------------------------------------------------------
`default_nettype none

package hpti_pkg;

  localparam int unsigned IdxBits   = 63;
  localparam int unsigned LevBits   = 5;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned MaxLevCap = 21;

  localparam logic [RegIdxW-1:0] RegDimMode = 3'd0;
  localparam logic [RegIdxW-1:0] RegLevels  = 3'd1;
  localparam logic [RegIdxW-1:0] RegMinX    = 3'd2;
  localparam logic [RegIdxW-1:0] RegMaxX    = 3'd3;
  localparam logic [RegIdxW-1:0] RegMinY    = 3'd4;
  localparam logic [RegIdxW-1:0] RegMaxY    = 3'd5;
  localparam logic [RegIdxW-1:0] RegMinZ    = 3'd6;
  localparam logic [RegIdxW-1:0] RegMaxZ    = 3'd7;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrBounds = 2'd1;
  localparam logic [1:0] ErrRange  = 2'd2;

  // Settings that travel with each item.
  typedef struct packed {
    logic               three;
    logic [LevBits-1:0] lev;
  } hpti_mode_t;

endpackage : hpti_pkg

`default_nettype wire

@@ rtl/core/hpti_div_cell.sv @@
// ----------------------------------------------------------------------------
// hpti_div_cell: one restoring-division step for three axes
// Produces one quotient bit per axis and hands the remainders on.
// ----------------------------------------------------------------------------
`default_nettype none

module hpti_div_cell
  import hpti_pkg::*;
#(
  parameter int unsigned CoordBits = 32,
  parameter int unsigned MaxLevels = 21
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   vld_i,
  input  wire hpti_mode_t             mode_i,
  input  wire logic [1:0]             err_i,
  input  wire logic [2:0]             sat_i,
  input  wire logic [3*CoordBits-1:0] den_i,
  input  wire logic [3*CoordBits-1:0] rem_i,
  input  wire logic [3*MaxLevels-1:0] quo_i,
  output logic                        vld_o,
  output hpti_mode_t                  mode_o,
  output logic [1:0]                  err_o,
  output logic [2:0]                  sat_o,
  output logic [3*CoordBits-1:0]      den_o,
  output logic [3*CoordBits-1:0]      rem_o,
  output logic [3*MaxLevels-1:0]      quo_o
);

  logic [3*CoordBits-1:0] rem_d;
  logic [3*MaxLevels-1:0] quo_d;

  // remainder stays below the divisor, so 2r fits in CoordBits+1 bits
  always_comb begin
    logic [CoordBits:0] r2;
    logic [CoordBits:0] dd;
    rem_d = '0;
    quo_d = '0;
    for (int a = 0; a < 3; a++) begin
      r2 = {rem_i[a*CoordBits +: CoordBits], 1'b0};
      dd = {1'b0, den_i[a*CoordBits +: CoordBits]};
      if (r2 >= dd) begin
        rem_d[a*CoordBits +: CoordBits] = CoordBits'(r2 - dd);
        quo_d[a*MaxLevels +: MaxLevels] = {quo_i[a*MaxLevels +: MaxLevels-1], 1'b1};
      end else begin
        rem_d[a*CoordBits +: CoordBits] = r2[CoordBits-1:0];
        quo_d[a*MaxLevels +: MaxLevels] = {quo_i[a*MaxLevels +: MaxLevels-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_o <= mode_i;
      err_o  <= err_i;
      sat_o  <= sat_i;
      den_o  <= den_i;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
    end
  end

endmodule : hpti_div_cell

`default_nettype wire

@@ rtl/core/hpti_curve_cell.sv @@
// ----------------------------------------------------------------------------
// hpti_curve_cell: one Hilbert refinement level
// Emits one digit and permutes/complements the remaining fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hpti_curve_cell
  import hpti_pkg::*;
#(
  parameter int unsigned MaxLevels = 21,
  parameter int unsigned Step      = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 vld_i,
  input  wire hpti_mode_t           mode_i,
  input  wire logic [1:0]           err_i,
  input  wire logic [MaxLevels-1:0] x_i,
  input  wire logic [MaxLevels-1:0] y_i,
  input  wire logic [MaxLevels-1:0] z_i,
  input  wire logic [IdxBits-1:0]   idx_i,
  output logic                      vld_o,
  output hpti_mode_t                mode_o,
  output logic [1:0]                err_o,
  output logic [MaxLevels-1:0]      x_o,
  output logic [MaxLevels-1:0]      y_o,
  output logic [MaxLevels-1:0]      z_o,
  output logic [IdxBits-1:0]        idx_o
);

  logic [MaxLevels-1:0] x_d, y_d, z_d;
  logic [IdxBits-1:0]   idx_d;

  // Fractions are left-aligned in MaxLevels bits; bits below lev stay zero
  // after shifting, and complement only touches the top lev bits.
  always_comb begin
    logic [MaxLevels-1:0] fm, sx, sy, sz, cx, cy, cz;
    logic                 bx, by, bz;
    logic [2:0]           dig;
    fm = '0;
    for (int k = 0; k < MaxLevels; k++) begin
      if (k >= MaxLevels - int'(mode_i.lev)) fm[k] = 1'b1;
    end
    bx = x_i[MaxLevels-1];
    by = y_i[MaxLevels-1];
    bz = z_i[MaxLevels-1];
    sx = (x_i << 1) & fm;
    sy = (y_i << 1) & fm;
    sz = (z_i << 1) & fm;
    cx = sx ^ fm;
    cy = sy ^ fm;
    cz = sz ^ fm;
    x_d = x_i; y_d = y_i; z_d = z_i; idx_d = idx_i; dig = 3'd0;
    if (vld_i && err_i == ErrNone && int'(mode_i.lev) > Step) begin
      if (!mode_i.three) begin
        case ({bx, by})
          2'b00:   begin dig = 3'd0; x_d = sy; y_d = sx; end
          2'b01:   begin dig = 3'd1; x_d = sx; y_d = sy; end
          2'b11:   begin dig = 3'd2; x_d = sx; y_d = sy; end
          default: begin dig = 3'd3; x_d = cy; y_d = cx; end
        endcase
        idx_d = {idx_i[IdxBits-3:0], dig[1:0]};
      end else begin
        case ({bz, bx, by})
          3'b000:  begin dig = 3'd0; x_d = sz; y_d = sx; z_d = sy; end
          3'b001:  begin dig = 3'd1; x_d = sy; y_d = sz; z_d = sx; end
          3'b011:  begin dig = 3'd2; x_d = sy; y_d = sz; z_d = sx; end
          3'b010:  begin dig = 3'd3; x_d = cx; y_d = cy; z_d = sz; end
          3'b110:  begin dig = 3'd4; x_d = cx; y_d = cy; z_d = sz; end
          3'b111:  begin dig = 3'd5; x_d = sy; y_d = cz; z_d = cx; end
          3'b100:  begin dig = 3'd7; x_d = cz; y_d = sx; z_d = cy; end
          default: begin dig = 3'd6; x_d = sy; y_d = cz; z_d = cx; end
        endcase
        idx_d = {idx_i[IdxBits-4:0], dig};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_o <= mode_i;
      err_o  <= err_i;
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      idx_o  <= idx_d;
    end
  end

endmodule : hpti_curve_cell

`default_nettype wire

@@ rtl/core/hilbert_point_to_index_top.sv @@
// ----------------------------------------------------------------------------
// hilbert_point_to_index_top: point to 2D/3D Hilbert curve index
// Scales each coordinate against its bounds, then walks the curve levels.
// ----------------------------------------------------------------------------
//  channel | dir | signals                    | contents
//  s_axis  | in  | s_axis_tvalid/tready/tdata | coord_x, coord_y, coord_z
//  m_axis  | out | m_axis_tvalid/tready/tdata | curve_index, error_code
//  cfg     | in  | cfg_we_i/idx_i/data_i      | eight registers, write only
//
//  One transaction per cycle sustained while results are taken.
//  Front stage checks bounds and forms numerator/divisor, then MAX_LEVELS
//  division cells make one fraction bit each, then MAX_LEVELS curve cells
//  make one digit each while within the level count. The whole chain advances
//  together: it stalls only when the output register is full and not taken.
//  Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hilbert_point_to_index_top
  import hpti_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 21,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // [CB-1:0] coord_x, [2CB-1:CB] coord_y, [3CB-1:2CB] coord_z
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [62:0] curve_index, [64:63] error_code, rest zero
  output logic [71:0]                  m_axis_tdata,
  input  wire logic                    cfg_we_i,
  input  wire logic [RegIdxW-1:0]      cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]   cfg_data_i
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned ML = MAX_LEVELS;
  localparam logic [CB-1:0] Sgn = {1'b1, {(CB-1){1'b0}}};

  // configuration registers
  logic          dim_q;
  logic [4:0]    lev_q;
  logic [CB-1:0] min_q [3];
  logic [CB-1:0] max_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= 1'b0;
      lev_q <= 5'd21;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= '0;
        max_q[a] <= ~Sgn;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDimMode: dim_q    <= cfg_data_i[0];
        RegLevels:  lev_q    <= cfg_data_i[4:0];
        RegMinX:    min_q[0] <= cfg_data_i;
        RegMaxX:    max_q[0] <= cfg_data_i;
        RegMinY:    min_q[1] <= cfg_data_i;
        RegMaxY:    max_q[1] <= cfg_data_i;
        RegMinZ:    min_q[2] <= cfg_data_i;
        RegMaxZ:    max_q[2] <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // chain enable: advance unless the output holds an untaken result
  logic out_vld_q;
  logic en;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // front stage: bias, compare, numerator and divisor
  hpti_mode_t      mode_f;
  logic [1:0]      err_f;
  logic [2:0]      sat_f;
  logic [3*CB-1:0] den_f, num_f;

  always_comb begin
    logic [CB-1:0] bp, bl, bh;
    logic [1:0]    ea;
    logic [1:0]    ev [3];
    mode_f.three = dim_q;
    mode_f.lev   = (lev_q > 5'(ML)) ? 5'(ML) : lev_q;
    sat_f = '0;
    den_f = '0;
    num_f = '0;
    for (int a = 0; a < 3; a++) begin
      bp = s_axis_tdata[a*CB +: CB] ^ Sgn;
      bl = min_q[a] ^ Sgn;
      bh = max_q[a] ^ Sgn;
      ea = ErrNone;
      if (bh <= bl) ea = ErrRange;
      else if (bp < bl || bp > bh) ea = ErrBounds;
      ev[a] = (a == 2 && !dim_q) ? ErrNone : ea;
      den_f[a*CB +: CB] = bh - bl;
      num_f[a*CB +: CB] = (ea == ErrNone) ? bp - bl : '0;
      sat_f[a] = (ea == ErrNone) && (bp == bh);
    end
    err_f = ev[0];
    if (ev[1] > err_f) err_f = ev[1];
    if (ev[2] > err_f) err_f = ev[2];
  end

  logic            vld_r;
  hpti_mode_t      mode_r;
  logic [1:0]      err_r;
  logic [2:0]      sat_r;
  logic [3*CB-1:0] den_r, num_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_r <= 1'b0;
    else if (en) vld_r <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_r <= mode_f;
      err_r  <= err_f;
      sat_r  <= sat_f;
      den_r  <= den_f;
      num_r  <= num_f;
    end
  end

  // division chain: ML cells, one quotient bit each
  logic            dv  [ML+1];
  hpti_mode_t      dm  [ML+1];
  logic [1:0]      de  [ML+1];
  logic [2:0]      ds  [ML+1];
  logic [3*CB-1:0] dd  [ML+1];
  logic [3*CB-1:0] dr  [ML+1];
  logic [3*ML-1:0] dq  [ML+1];

  assign dv[0] = vld_r;
  assign dm[0] = mode_r;
  assign de[0] = err_r;
  assign ds[0] = sat_r;
  assign dd[0] = den_r;
  assign dr[0] = num_r;
  assign dq[0] = '0;

  for (genvar g = 0; g < ML; g++) begin : g_div
    hpti_div_cell #(.CoordBits(CB), .MaxLevels(ML)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(dv[g]), .mode_i(dm[g]), .err_i(de[g]), .sat_i(ds[g]),
      .den_i(dd[g]), .rem_i(dr[g]), .quo_i(dq[g]),
      .vld_o(dv[g+1]), .mode_o(dm[g+1]), .err_o(de[g+1]), .sat_o(ds[g+1]),
      .den_o(dd[g+1]), .rem_o(dr[g+1]), .quo_o(dq[g+1])
    );
  end

  // quotient q has ML bits of 2^ML scale; keep the top lev bits, left-aligned
  logic [ML-1:0] fx [3];
  always_comb begin
    logic [ML-1:0] fm;
    fm = '0;
    for (int k = 0; k < ML; k++) begin
      if (k >= ML - int'(dm[ML].lev)) fm[k] = 1'b1;
    end
    for (int a = 0; a < 3; a++) begin
      if (de[ML] != ErrNone || (a == 2 && !dm[ML].three)) fx[a] = '0;
      else if (ds[ML][a]) fx[a] = fm;
      else fx[a] = dq[ML][a*ML +: ML] & fm;
    end
  end

  // curve chain
  logic               cv [ML+1];
  hpti_mode_t         cm [ML+1];
  logic [1:0]         ce [ML+1];
  logic [ML-1:0]      cx [ML+1];
  logic [ML-1:0]      cy [ML+1];
  logic [ML-1:0]      cz [ML+1];
  logic [IdxBits-1:0] ci [ML+1];

  assign cv[0] = dv[ML];
  assign cm[0] = dm[ML];
  assign ce[0] = de[ML];
  assign cx[0] = fx[0];
  assign cy[0] = fx[1];
  assign cz[0] = fx[2];
  assign ci[0] = '0;

  for (genvar g = 0; g < ML; g++) begin : g_curve
    hpti_curve_cell #(.MaxLevels(ML), .Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(cv[g]), .mode_i(cm[g]), .err_i(ce[g]),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .idx_i(ci[g]),
      .vld_o(cv[g+1]), .mode_o(cm[g+1]), .err_o(ce[g+1]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]), .idx_o(ci[g+1])
    );
  end

  // output register
  logic [IdxBits-1:0] idx_q;
  logic [1:0]         err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= cv[ML];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q <= ci[ML];
      err_q <= ce[ML];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, err_q, idx_q};

endmodule : hilbert_point_to_index_top

`default_nettype wire

@@ rtl/core/hpti_checker.sv @@
// ----------------------------------------------------------------------------
// hpti_checker: port-level checks for the Hilbert point-to-index block
// Watches stream handshakes and result encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module hpti_checker
  import hpti_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // error code never 3
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[64:63] != 2'd3)
    else $error("bad error code");

  // an error result carries index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[64:63] != ErrNone |-> m_axis_tdata[62:0] == '0)
    else $error("nonzero index on error");

  // input side is free whenever output is empty or drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled without output backpressure");

endmodule : hpti_checker

bind hilbert_point_to_index_top hpti_checker u_hpti_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

`default_nettype wire

@@ verif/hpti_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpti_tb_checker: scoreboard for the Hilbert point-to-index block
// Tracks register writes, predicts the curve index and error code of every
// accepted point, and compares each output transaction in order.
// ----------------------------------------------------------------------------

module hpti_tb_checker
  import hpti_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [71:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [RegIdxW-1:0]   cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [62:0] curve_index;
    logic [1:0]  error_code;
  } curve_result_t;

  logic        mode_3d;
  logic [4:0]  lev_reg;
  logic [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

  curve_result_t expected_results[$];

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    fail_count_o++;
  endtask

  // Scales one axis to a lev-bit fraction; returns the error code.
  function automatic logic [1:0] scale_axis(input logic [31:0] p, lo, hi, input int lev,
                                            output logic [63:0] frac);
    logic [63:0] bp, bl, bh, num, den, rem, q, fmask;
    bp = {32'd0, ~p[31], p[30:0]};
    bl = {32'd0, ~lo[31], lo[30:0]};
    bh = {32'd0, ~hi[31], hi[30:0]};
    fmask = (64'd1 << lev) - 64'd1;
    frac = '0;
    q = '0;
    if (bh <= bl) return ErrRange;
    if (bp < bl || bp > bh) return ErrBounds;
    num = bp - bl;
    den = bh - bl;
    if (num == den) begin
      frac = fmask;
      return ErrNone;
    end
    rem = num;
    for (int i = 0; i < lev; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    frac = q & fmask;
    return ErrNone;
  endfunction

  function automatic curve_result_t curve_of_point(input logic [31:0] px, py, pz);
    curve_result_t res;
    int lev, top;
    logic [63:0] x, y, z, sx, sy, sz, cx, cy, cz, fmask, idx;
    logic [1:0] ex, ey, ez, err;
    logic bx, by, bz;
    lev = (lev_reg > MaxLevCap) ? MaxLevCap : int'(lev_reg);
    fmask = (64'd1 << lev) - 64'd1;
    z = '0;
    ez = ErrNone;
    ex = scale_axis(px, lo_x, hi_x, lev, x);
    ey = scale_axis(py, lo_y, hi_y, lev, y);
    if (mode_3d) ez = scale_axis(pz, lo_z, hi_z, lev, z);
    err = ex;
    if (ey > err) err = ey;
    if (ez > err) err = ez;
    res.error_code = err;
    res.curve_index = '0;
    if (err != ErrNone) return res;
    idx = '0;
    top = (lev > 0) ? lev - 1 : 0;
    for (int i = 0; i < lev; i++) begin
      bx = x[top];
      by = y[top];
      bz = z[top];
      sx = (x << 1) & fmask;
      sy = (y << 1) & fmask;
      sz = (z << 1) & fmask;
      cx = sx ^ fmask;
      cy = sy ^ fmask;
      cz = sz ^ fmask;
      if (!mode_3d) begin
        case ({bx, by})
          2'b00:   begin idx = (idx << 2) | 0; x = sy; y = sx; end
          2'b01:   begin idx = (idx << 2) | 1; x = sx; y = sy; end
          2'b11:   begin idx = (idx << 2) | 2; x = sx; y = sy; end
          default: begin idx = (idx << 2) | 3; x = cy; y = cx; end
        endcase
      end else begin
        case ({bz, bx, by})
          3'b000:  begin idx = (idx << 3) | 0; x = sz; y = sx; z = sy; end
          3'b001:  begin idx = (idx << 3) | 1; x = sy; y = sz; z = sx; end
          3'b011:  begin idx = (idx << 3) | 2; x = sy; y = sz; z = sx; end
          3'b010:  begin idx = (idx << 3) | 3; x = cx; y = cy; z = sz; end
          3'b110:  begin idx = (idx << 3) | 4; x = cx; y = cy; z = sz; end
          3'b111:  begin idx = (idx << 3) | 5; x = sy; y = cz; z = cx; end
          3'b100:  begin idx = (idx << 3) | 7; x = cz; y = sx; z = cy; end
          default: begin idx = (idx << 3) | 6; x = sy; y = cz; z = cx; end
        endcase
      end
    end
    res.curve_index = idx[62:0];
    return res;
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    curve_result_t got, want;
    if (!rst_ni) begin
      mode_3d = 1'b0;
      lev_reg = 5'd21;
      lo_x = '0; lo_y = '0; lo_z = '0;
      hi_x = 32'h7fff_ffff; hi_y = 32'h7fff_ffff; hi_z = 32'h7fff_ffff;
      expected_results.delete();
      pending_o = 0;
    end else begin
      // a point taken at this edge sees the registers from before the edge
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(curve_of_point(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                                  s_axis_tdata[95:64]));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDimMode: mode_3d = cfg_data_i[0];
          RegLevels:  lev_reg = cfg_data_i[4:0];
          RegMinX:    lo_x = cfg_data_i;
          RegMaxX:    hi_x = cfg_data_i;
          RegMinY:    lo_y = cfg_data_i;
          RegMaxY:    hi_y = cfg_data_i;
          RegMinZ:    lo_z = cfg_data_i;
          RegMaxZ:    hi_z = cfg_data_i;
          default:    ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.curve_index = m_axis_tdata[62:0];
        got.error_code = m_axis_tdata[64:63];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, {1'b0, got.curve_index});
        end else begin
          want = expected_results.pop_front();
          if (got.curve_index != want.curve_index)
            report_mismatch("curve_index", {1'b0, want.curve_index}, {1'b0, got.curve_index});
          if (got.error_code != want.error_code)
            report_mismatch("error_code", 64'(want.error_code), 64'(got.error_code));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ verif/hilbert_point_to_index_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hilbert_point_to_index_top_tb: testbench for the Hilbert point-to-index top
// Drives points through several register settings with random idling on both
// stream sides; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module hilbert_point_to_index_top_tb;
  import hpti_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [95:0]        s_axis_tdata;   // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [71:0]        m_axis_tdata;   // [62:0] curve_index, [64:63] error_code
  logic               cfg_we_i;
  logic [RegIdxW-1:0] cfg_idx_i;
  logic [31:0]        cfg_data_i;

  int fail_count;
  int pending;

  // Idle percentages for each side, and the receiver hold-off request.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;

  // Bounds currently programmed, mirrored for stimulus shaping.
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 60;   // idle wait, longer than the pipeline latency

  hilbert_point_to_index_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  hpti_tb_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random backpressure, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // One point: held valid until the block takes it, then maybe a gap.
  task automatic send_point(input logic [31:0] x, y, z);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Full register setting; only called while the pipeline is empty.
  task automatic program_curve(input logic dim3, input logic [4:0] lev,
                               input logic signed [31:0] ax, bx, ay, by, az, bz);
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(RegDimMode, {31'd0, dim3});
    write_reg(RegLevels, {27'd0, lev});
    write_reg(RegMinX, ax);
    write_reg(RegMaxX, bx);
    write_reg(RegMinY, ay);
    write_reg(RegMaxY, by);
    write_reg(RegMinZ, az);
    write_reg(RegMaxZ, bz);
    lo_x = ax; hi_x = bx; lo_y = ay; hi_y = by; lo_z = az; hi_z = bz;
  endtask

  // Mostly in-bounds coordinates, with bound edges and strays mixed in.
  function automatic logic [31:0] pick_coord(input logic signed [31:0] lo, hi);
    longint unsigned span;
    int sel;
    sel = $urandom_range(99);
    if (hi <= lo || sel < 8) return $urandom;
    if (sel < 14) return lo;
    if (sel < 20) return hi;
    if (sel < 23) return lo - 1;
    if (sel < 26) return hi + 1;
    span = longint'(hi) - longint'(lo) + 1;
    return lo + 32'({$urandom, $urandom} % span);
  endfunction

  task automatic random_points(input int count);
    for (int i = 0; i < count; i++)
      send_point(pick_coord(lo_x, hi_x), pick_coord(lo_y, hi_y), pick_coord(lo_z, hi_z));
  endtask

  initial begin
    logic signed [31:0] a, b;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegDimMode;
    cfg_data_i    = '0;
    send_idle_pct = 34;
    recv_idle_pct = 66;
    hold_req      = 0;
    hold_left     = 0;
    lo_x = 0; lo_y = 0; lo_z = 0;
    hi_x = 32'h7fff_ffff; hi_y = 32'h7fff_ffff; hi_z = 32'h7fff_ffff;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset setting (2D, 21 levels), corners, saturation, strays.
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
    send_point(32'h7fff_ffff, 32'd0, 32'd0);
    send_point(32'd0, 32'h7fff_ffff, 32'd0);
    send_point(32'h4000_0000, 32'h3fff_ffff, 32'hffff_ffff);
    send_point(32'hffff_ffff, 32'd5, 32'd0);           // x below min
    send_point(32'd5, 32'h8000_0000, 32'd0);           // y below min
    // Full signed range, 3D: every octant corner and the extremes.
    program_curve(1'b1, 5'd21, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    for (int k = 0; k < 8; k++)
      send_point(k[1] ? 32'h7fff_ffff : 32'h8000_0000, k[0] ? 32'h7fff_ffff : 32'h8000_0000,
                 k[2] ? 32'h7fff_ffff : 32'h8000_0000);
    send_point(32'h0, 32'hffff_ffff, 32'h1);
    // Empty range on z: range error wins over an out-of-bounds x.
    program_curve(1'b1, 5'd21, 32'sd0, 32'sd10, 32'sd0, 32'sd10, 32'sd7, 32'sd7);
    send_point(32'd100, 32'd3, 32'd7);
    send_point(32'd3, 32'd3, 32'd7);
    // Zero levels: index is zero, bound checks still apply.
    program_curve(1'b0, 5'd0, -32'sd50, 32'sd50, -32'sd50, 32'sd50, 32'sd0, 32'sd0);
    send_point(32'd10, -32'd20, 32'd0);
    send_point(32'd51, 32'd0, 32'd0);

    // Random part: sender idles 34%, receiver 66%.
    program_curve(1'b0, 5'd31, -32'sd100, 32'sd100, -32'sd1000, 32'sd999, 32'sd0, 32'sd0);
    random_points(60);
    program_curve(1'b1, 5'd21, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    random_points(100);
    program_curve(1'b0, 5'd21, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sd0, 32'sd0);
    random_points(100);

    // Swap idle rates.
    send_idle_pct = 66;
    recv_idle_pct = 34;
    for (int ph = 0; ph < 4; ph++) begin
      a = $urandom;
      b = a + $urandom_range(5000, 1);
      program_curve(1'($urandom_range(1)), 5'($urandom_range(21)), a, b, -32'sd3, 32'sd4,
                    $urandom_range(1) ? a : b, b);   // z range sometimes empty
      random_points(60);
    end

    // No idling; long receiver hold-off fills the pipeline and stalls input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_curve(1'b1, 5'd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1);
    hold_req = 300;
    random_points(120);
    // Sender pauses until everything has come back, then carries on.
    drain();
    program_curve(1'b1, 5'd13, -32'sd4096, 32'sd4095, 32'sd0, 32'sd255, 32'sd100,
                  32'sd100000);
    random_points(160);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hpti_pkg.sv
rtl/core/hpti_div_cell.sv
rtl/core/hpti_curve_cell.sv
rtl/core/hilbert_point_to_index_top.sv
rtl/core/hpti_checker.sv
verif/hpti_checker.sv
verif/hilbert_point_to_index_top_tb.sv
